[rtl/core/ael_pkg.sv]
// Alarm event log: shared sizes, codes and types.
// Depends on nothing; used by the interfaces, the cell and the core.
`default_nettype none

package ael_pkg;

    // Log geometry
    localparam int LOG_DEPTH = 16;   // entries held, 1 to 31
    localparam int ID_COUNT  = 16;   // valid ids are 1 .. ID_COUNT-1, 2 to 256

    // Field widths of one word
    localparam int ACTION_W  = 2;
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 16;
    localparam int RIDX_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int ECNT_W    = 5;

    // Count register holds 0 .. LOG_DEPTH
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    // Width for comparing the read index with the count
    localparam int CMP_W     = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RAISE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } ael_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_CLEARED  = 3'd2,
        ST_NO_MATCH = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_MISS     = 3'd5
    } ael_status_t;

    // One log entry
    typedef struct packed {
        logic        [ID_W-1:0]   id;
        logic        [PRIO_W-1:0] prio;
        logic        [TIME_W-1:0] raised;
        logic        [TIME_W-1:0] cleared;
        logic signed [VAL_W-1:0]  limit;
        logic signed [VAL_W-1:0]  measured;
    } ael_entry_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic              shift;     // good raise: every cell takes its neighbour
        logic              clr_en;    // clear word accepted
        logic [ID_W-1:0]   clr_id;
        logic [TIME_W-1:0] now_time;
    } ael_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ael_in_if.sv]
// Request channel of the alarm event log: valid/ready plus the request word.
// Depends on ael_pkg.
`default_nettype none

interface ael_in_if;
    logic                                valid;
    logic                                ready;
    logic        [ael_pkg::ACTION_W-1:0] action;
    logic        [ael_pkg::ID_W-1:0]     alarm_id;
    logic        [ael_pkg::PRIO_W-1:0]   alarm_priority;
    logic        [ael_pkg::TIME_W-1:0]   now_time;
    logic signed [ael_pkg::VAL_W-1:0]    limit_hundredths;
    logic signed [ael_pkg::VAL_W-1:0]    measured_hundredths;
    logic        [ael_pkg::RIDX_W-1:0]   read_index;

    modport source (
        output valid, action, alarm_id, alarm_priority, now_time,
               limit_hundredths, measured_hundredths, read_index,
        input  ready
    );

    modport sink (
        input  valid, action, alarm_id, alarm_priority, now_time,
               limit_hundredths, measured_hundredths, read_index,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ael_out_if.sv]
// Response channel of the alarm event log: valid/ready plus the result word.
// Depends on ael_pkg.
`default_nettype none

interface ael_out_if;
    logic                                valid;
    logic                                ready;
    logic        [ael_pkg::STATUS_W-1:0] status;
    logic        [ael_pkg::ECNT_W-1:0]   entry_count;
    logic        [ael_pkg::ID_W-1:0]     out_id;
    logic        [ael_pkg::PRIO_W-1:0]   out_priority;
    logic        [ael_pkg::TIME_W-1:0]   out_raised;
    logic        [ael_pkg::TIME_W-1:0]   out_cleared;
    logic signed [ael_pkg::VAL_W-1:0]    out_limit;
    logic signed [ael_pkg::VAL_W-1:0]    out_measured;

    modport source (
        output valid, status, entry_count, out_id, out_priority, out_raised,
               out_cleared, out_limit, out_measured,
        input  ready
    );

    modport sink (
        input  valid, status, entry_count, out_id, out_priority, out_raised,
               out_cleared, out_limit, out_measured,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ael_cell.sv]
// One position of the alarm log: holds an entry and its valid bit, shifts
// from its newer neighbour on raise and stamps itself on clear. Uses ael_pkg.
`default_nettype none

module ael_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire ael_pkg::ael_cell_ctrl_t ctrl,
    input  wire ael_pkg::ael_entry_t    prev_entry,
    input  wire                         prev_valid,
    input  wire                         found_in,
    output ael_pkg::ael_entry_t         entry,
    output logic                        valid,
    output logic                        found_out,
    output logic                        stamp
);

    ael_pkg::ael_entry_t entry_reg;
    ael_pkg::ael_entry_t entry_next;
    logic                valid_reg;
    logic                valid_next;
    logic                match;

    // Open entry with the wanted id; only the newest such one is stamped
    assign match     = valid_reg && (entry_reg.id == ctrl.clr_id)
                       && (entry_reg.cleared == '0);
    assign stamp     = ctrl.clr_en && match && !found_in;
    assign found_out = found_in || match;

    // Next entry: shift on raise, stamp clear time on clear
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            entry_next = prev_entry;
            valid_next = prev_valid;
        end
        else if (stamp)
        begin
            entry_next.cleared = ctrl.now_time;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload, meaningful only while valid
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

[rtl/core/alarm_event_log_core.sv]
// Alarm event log top level: a chain of ael_cell positions, newest first,
// a count register and a registered response. Uses ael_pkg, ael_in_if,
// ael_out_if and ael_cell.
//
//  Channel | Dir | Word
//  --------+-----+-----------------------------------------------------------
//  req     | in  | action, alarm id/priority, time, limit, measured, index
//  rsp     | out | status, entry count, entry read (zero unless read ok)
//
// One request word per cycle when ready; its response appears in the output
// register the cycle after acceptance. The clear search ripples a found flag
// down the cell chain in the same cycle, and the read is a select across the
// cells. req.ready is low only while a response waits and rsp.ready is low.
// Reset clears the cell valid bits and the count at once; no clearing pass.
`default_nettype none

module alarm_event_log_core (
    input  wire        clk,
    input  wire        rst_n,
    ael_in_if.sink     req,
    ael_out_if.source  rsp
);

    localparam int N = ael_pkg::LOG_DEPTH;

    ael_pkg::ael_cell_ctrl_t         ctrl;
    ael_pkg::ael_entry_t             chain_entry [0:N];
    logic [N:0]                      valid_vec;
    logic [N:0]                      found_vec;
    logic [N-1:0]                    stamp_vec;
    ael_pkg::ael_entry_t             new_entry;
    ael_pkg::ael_entry_t             sel_entry;

    logic [ael_pkg::CNT_W-1:0]       count_reg;
    logic [ael_pkg::CNT_W-1:0]       count_next;
    logic                            accept;
    logic                            id_ok;
    logic                            idx_ok;
    logic                            not_full;

    ael_pkg::ael_status_t            status_c;
    ael_pkg::ael_entry_t             rdata_c;
    logic                            shift_c;
    logic                            clr_c;

    logic                            rsp_valid_reg;
    ael_pkg::ael_status_t            status_reg;
    logic [ael_pkg::ECNT_W-1:0]      ecount_reg;
    ael_pkg::ael_entry_t             rdata_reg;

    // Handshake: one output register parts the two sides
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Request decode
    assign id_ok    = (req.alarm_id != '0)
                      && ({1'b0, req.alarm_id} < (ael_pkg::ID_W + 1)'(ael_pkg::ID_COUNT));
    assign idx_ok   = ael_pkg::CMP_W'(req.read_index) < ael_pkg::CMP_W'(count_reg);
    assign not_full = count_reg < ael_pkg::CNT_W'(N);

    // New entry entering at the front
    always_comb
    begin
        new_entry          = '0;
        new_entry.id       = req.alarm_id;
        new_entry.prio     = req.alarm_priority;
        new_entry.raised   = req.now_time;
        new_entry.limit    = req.limit_hundredths;
        new_entry.measured = req.measured_hundredths;
    end

    // Read select across the cells
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (req.read_index == ael_pkg::RIDX_W'(i))
            begin
                sel_entry = chain_entry[i+1];
            end
        end
    end

    // Result and state control per action
    always_comb
    begin
        status_c   = ael_pkg::ST_MISS;
        rdata_c    = '0;
        shift_c    = 1'b0;
        clr_c      = 1'b0;
        count_next = count_reg;
        case (ael_pkg::ael_action_t'(req.action))
            ael_pkg::ACT_RAISE:
            begin
                if (id_ok)
                begin
                    status_c = ael_pkg::ST_RECORDED;
                    shift_c  = 1'b1;
                    if (not_full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    status_c = ael_pkg::ST_BAD_ID;
                end
            end
            ael_pkg::ACT_CLEAR:
            begin
                clr_c    = 1'b1;
                status_c = found_vec[N] ? ael_pkg::ST_CLEARED : ael_pkg::ST_NO_MATCH;
            end
            ael_pkg::ACT_READ:
            begin
                if (idx_ok)
                begin
                    status_c = ael_pkg::ST_READ_OK;
                    rdata_c  = sel_entry;
                end
            end
            default:
            begin
                status_c = ael_pkg::ST_MISS;
            end
        endcase
    end

    // Broadcast control to the cells
    always_comb
    begin
        ctrl.shift    = accept && shift_c;
        ctrl.clr_en   = accept && clr_c;
        ctrl.clr_id   = req.alarm_id;
        ctrl.now_time = req.now_time;
    end

    // Cell chain, position 0 newest
    assign chain_entry[0] = new_entry;
    assign valid_vec[0]   = 1'b1;
    assign found_vec[0]   = 1'b0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ael_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (chain_entry[g]),
            .prev_valid (valid_vec[g]),
            .found_in   (found_vec[g]),
            .entry      (chain_entry[g+1]),
            .valid      (valid_vec[g+1]),
            .found_out  (found_vec[g+1]),
            .stamp      (stamp_vec[g])
        );
    end

    // Count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_c;
            ecount_reg <= ael_pkg::ECNT_W'(count_next);
            rdata_reg  <= rdata_c;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.entry_count  = ecount_reg;
    assign rsp.out_id       = rdata_reg.id;
    assign rsp.out_priority = rdata_reg.prio;
    assign rsp.out_raised   = rdata_reg.raised;
    assign rsp.out_cleared  = rdata_reg.cleared;
    assign rsp.out_limit    = rdata_reg.limit;
    assign rsp.out_measured = rdata_reg.measured;

    // Cell valid bits track the count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec[N:1]) == count_reg)
        else $error("cell valid bits disagree with entry count");

    // Valid cells form an unbroken run from the front
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec[N:1] >> 1) & ~valid_vec[N:1]) == '0)
        else $error("gap in valid cells");

    // A clear stamps at most one entry
    a_one_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stamp_vec))
        else $error("more than one cell stamped");

    // A stamp only happens when the clear reports a match
    a_stamp_status: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_vec != '0) |-> (ctrl.clr_en && found_vec[N]))
        else $error("stamp without a reported match");

    // A recorded raise leaves a non-empty log
    a_raise_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.shift) |=> (count_reg != '0 && valid_vec[1]))
        else $error("raise did not fill the front cell");

endmodule

`default_nettype wire

[test/alarm_event_log_core_tb.sv]
// Self-checking testbench for alarm_event_log_core: directed table, then random words,
// each response checked against its typed answer or a behavioural copy of the log.
// Depends on ael_pkg, ael_in_if, ael_out_if and the alarm_event_log_core RTL.
module alarm_event_log_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ael_pkg::*;

    // Spare action code: the core answers it with an index miss
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 400;

    // One request word as offered on the req channel
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [ID_W-1:0]         alarm_id;
        logic [PRIO_W-1:0]       alarm_priority;
        logic [TIME_W-1:0]       now_time;
        logic signed [VAL_W-1:0] limit_hundredths;
        logic signed [VAL_W-1:0] measured_hundredths;
        logic [RIDX_W-1:0]       read_index;
    } alarm_word_t;

    // One response word
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ECNT_W-1:0]       entry_count;
        logic [ID_W-1:0]         id;
        logic [PRIO_W-1:0]       prio;
        logic [TIME_W-1:0]       raised;
        logic [TIME_W-1:0]       cleared;
        logic signed [VAL_W-1:0] limit;
        logic signed [VAL_W-1:0] measured;
    } log_result_t;

    // One stored alarm
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [PRIO_W-1:0]       prio;
        logic [TIME_W-1:0]       raised;
        logic [TIME_W-1:0]       cleared;
        logic signed [VAL_W-1:0] limit;
        logic signed [VAL_W-1:0] measured;
    } alarm_rec_t;

    // Directed row: a word, how often to send it, and an optional typed answer
    typedef struct {
        alarm_word_t         w;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic [ECNT_W-1:0]   cnt;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ael_in_if  req_if ();
    ael_out_if rsp_if ();

    alarm_event_log_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Testbench copy of the log, newest at position 0
    alarm_rec_t  alarm_log [LOG_DEPTH];
    int unsigned log_fill;

    log_result_t pending_results [$];
    stim_row_t   dir_rows [$];

    // Word currently on the req channel, with its typed answer if any
    alarm_word_t offered_word;
    bit          offered_typed;
    log_result_t offered_exp;

    int mismatches   = 0;
    int results_seen = 0;
    int tx_gap_max   = 15;
    int rx_gap_max   = 15;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Apply one word to the log copy and return the response it should give
    function automatic log_result_t next_log_result(input alarm_word_t w);
        log_result_t r;
        int          keep;
        bit          found;
        r     = '0;
        found = 1'b0;
        case (w.action)
            ACT_RAISE:
            begin
                if (w.alarm_id == 0 || int'(w.alarm_id) >= ID_COUNT)
                begin
                    r.status = ST_BAD_ID;
                end
                else
                begin
                    keep = (log_fill < LOG_DEPTH) ? log_fill : LOG_DEPTH - 1;
                    for (int i = keep; i > 0; i--)
                        alarm_log[i] = alarm_log[i-1];
                    alarm_log[0] = '{w.alarm_id, w.alarm_priority, w.now_time, '0,
                                     w.limit_hundredths, w.measured_hundredths};
                    if (log_fill < LOG_DEPTH)
                        log_fill++;
                    r.status = ST_RECORDED;
                end
            end
            ACT_CLEAR:
            begin
                // newest open entry with this id takes the clear time
                for (int i = 0; i < log_fill && !found; i++)
                begin
                    if (alarm_log[i].id == w.alarm_id && alarm_log[i].cleared == 0)
                    begin
                        alarm_log[i].cleared = w.now_time;
                        found = 1'b1;
                    end
                end
                r.status = found ? ST_CLEARED : ST_NO_MATCH;
            end
            ACT_READ:
            begin
                if (w.read_index < log_fill)
                begin
                    r.status   = ST_READ_OK;
                    r.id       = alarm_log[w.read_index].id;
                    r.prio     = alarm_log[w.read_index].prio;
                    r.raised   = alarm_log[w.read_index].raised;
                    r.cleared  = alarm_log[w.read_index].cleared;
                    r.limit    = alarm_log[w.read_index].limit;
                    r.measured = alarm_log[w.read_index].measured;
                end
                else
                begin
                    r.status = ST_MISS;
                end
            end
            default:
            begin
                r.status = ST_MISS;
            end
        endcase
        r.entry_count = log_fill[ECNT_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Response checking, then prediction for a word taken at this edge
    always @(posedge clk)
    begin : check_and_predict
        log_result_t got;
        log_result_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.status      = rsp_if.status;
                got.entry_count = rsp_if.entry_count;
                got.id          = rsp_if.out_id;
                got.prio        = rsp_if.out_priority;
                got.raised      = rsp_if.out_raised;
                got.cleared     = rsp_if.out_cleared;
                got.limit       = rsp_if.out_limit;
                got.measured    = rsp_if.out_measured;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("response word with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                    compare_field("out_id", want.id, got.id);
                    compare_field("out_priority", want.prio, got.prio);
                    compare_field("out_raised", want.raised, got.raised);
                    compare_field("out_cleared", want.cleared, got.cleared);
                    compare_field("out_limit", want.limit, got.limit);
                    compare_field("out_measured", want.measured, got.measured);
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                want = next_log_result(offered_word);
                if (offered_typed)
                    want = offered_exp;
                pending_results.push_back(want);
            end
        end
    end

    // Response side: random stall per word, one long hold-off mid run
    initial
    begin : rsp_sink
        int  gap;
        bit  held_off;
        held_off     = 1'b0;
        rsp_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
            if (!held_off && results_seen >= 500)
            begin
                gap      = HOLD_CYCLES;
                held_off = 1'b1;
            end
            repeat (gap)
            begin
                @(negedge clk);
                rsp_if.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    // Offer one word after a random gap and wait for it to be taken
    task automatic send_word(input alarm_word_t w, input bit typed, input log_result_t exp);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
        repeat (gap)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid               <= 1'b1;
        req_if.action              <= w.action;
        req_if.alarm_id            <= w.alarm_id;
        req_if.alarm_priority      <= w.alarm_priority;
        req_if.now_time            <= w.now_time;
        req_if.limit_hundredths    <= w.limit_hundredths;
        req_if.measured_hundredths <= w.measured_hundredths;
        req_if.read_index          <= w.read_index;
        offered_word               <= w;
        offered_typed              <= typed;
        offered_exp                <= exp;
        do @(posedge clk); while (!req_if.ready);
    endtask

    function automatic stim_row_t mk_row(
        input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
        input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] t,
        input logic [VAL_W-1:0] lim, input logic [VAL_W-1:0] meas,
        input logic [RIDX_W-1:0] idx, input int reps, input bit typed,
        input logic [STATUS_W-1:0] st, input logic [ECNT_W-1:0] cnt);
        stim_row_t r;
        r.w     = '{act, id, prio, t, lim, meas, idx};
        r.reps  = reps;
        r.typed = typed;
        r.st    = st;
        r.cnt   = cnt;
        return r;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        alarm_word_t w;
        log_result_t exp;
        int          sel;
        int          drain;

        log_fill                   = 0;
        for (int i = 0; i < LOG_DEPTH; i++)
            alarm_log[i] = '0;
        rst_n                      = 1'b0;
        req_if.valid               = 1'b0;
        req_if.action              = '0;
        req_if.alarm_id            = '0;
        req_if.alarm_priority      = '0;
        req_if.now_time            = '0;
        req_if.limit_hundredths    = '0;
        req_if.measured_hundredths = '0;
        req_if.read_index          = '0;
        offered_word               = '0;
        offered_typed              = 1'b0;
        offered_exp                = '0;

        // empty log, bad ids, spare action code
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  0, 1, 1, ST_MISS, 0));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0, 63, 1, 1, ST_MISS, 0));
        dir_rows.push_back(mk_row(ACT_CLEAR,  5,   0, 100, 0, 0, 0, 1, 1, ST_NO_MATCH, 0));
        dir_rows.push_back(mk_row(ACT_RAISE,  0,   9, 10, 1, 1, 0, 1, 1, ST_BAD_ID, 0));
        dir_rows.push_back(mk_row(ACT_RAISE, ID_W'(ID_COUNT), 9, 10, 1, 1, 0, 1, 1,
                                  ST_BAD_ID, 0));
        dir_rows.push_back(mk_row(ACT_RAISE, 255, 9, 10, 1, 1, 0, 1, 1, ST_BAD_ID, 0));
        dir_rows.push_back(mk_row(ACT_UNUSED, 3,   3, 3, 3, 3,  0, 1, 1, ST_MISS, 0));
        // extreme field values on raise, read back
        dir_rows.push_back(mk_row(ACT_RAISE,  1,   0, 0, 16'h8000, 16'h7fff, 0, 1, 1,
                                  ST_RECORDED, 1));
        dir_rows.push_back(mk_row(ACT_RAISE, ID_W'(ID_COUNT - 1), 8'hff, 32'hffff_ffff,
                                  16'h7fff, 16'h8000, 0, 1, 1, ST_RECORDED, 2));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  0, 1, 0, ST_READ_OK, 0));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  1, 1, 0, ST_READ_OK, 0));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  2, 1, 1, ST_MISS, 2));
        // clearing with a zero time leaves the entry open
        dir_rows.push_back(mk_row(ACT_CLEAR,  1,   0, 0, 0, 0,  0, 1, 1, ST_CLEARED, 2));
        dir_rows.push_back(mk_row(ACT_CLEAR,  1,   0, 32'hdead_beef, 0, 0, 0, 1, 1,
                                  ST_CLEARED, 2));
        dir_rows.push_back(mk_row(ACT_CLEAR,  1,   0, 5, 0, 0,  0, 1, 1, ST_NO_MATCH, 2));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  1, 1, 0, ST_READ_OK, 0));
        // clear ids outside the raise range are simply not found
        dir_rows.push_back(mk_row(ACT_CLEAR, 200,  0, 7, 0, 0,  0, 1, 1, ST_NO_MATCH, 2));
        dir_rows.push_back(mk_row(ACT_CLEAR,  0,   0, 7, 0, 0,  0, 1, 1, ST_NO_MATCH, 2));
        // fill past the depth so the oldest alarm drops out
        dir_rows.push_back(mk_row(ACT_RAISE,  7,  42, 1000, 16'hff9c, 250, 0, LOG_DEPTH - 1,
                                  0, ST_RECORDED, 0));
        dir_rows.push_back(mk_row(ACT_CLEAR,  7,   0, 32'hffff_ffff, 0, 0, 0, 1, 1,
                                  ST_CLEARED, ECNT_W'(LOG_DEPTH)));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0,  0, 1, 0, ST_READ_OK, 0));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0, RIDX_W'(LOG_DEPTH - 1), 1, 0,
                                  ST_READ_OK, 0));
        dir_rows.push_back(mk_row(ACT_READ,   0,   0, 0, 0, 0, RIDX_W'(LOG_DEPTH), 1, 1,
                                  ST_MISS, ECNT_W'(LOG_DEPTH)));
        dir_rows.push_back(mk_row(ACT_UNUSED, 7,   1, 1, 1, 1,  5, 1, 1, ST_MISS,
                                  ECNT_W'(LOG_DEPTH)));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (dir_rows[k])
        begin
            exp             = '0;
            exp.status      = dir_rows[k].st;
            exp.entry_count = dir_rows[k].cnt;
            repeat (dir_rows[k].reps)
                send_word(dir_rows[k].w, dir_rows[k].typed, exp);
        end

        // Random words, four idling phases: both, none, sender only, receiver only
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_gap_max = (ph == 0 || ph == 2) ? 15 : 0;
            rx_gap_max = (ph == 0 || ph == 3) ? 15 : 0;
            repeat (PHASE_WORDS)
            begin
                sel = $urandom_range(99, 0);
                if (sel < 40)
                    w.action = ACT_RAISE;
                else if (sel < 65)
                    w.action = ACT_CLEAR;
                else if (sel < 95)
                    w.action = ACT_READ;
                else
                    w.action = ACT_UNUSED;
                // mostly ids in range so clears find open alarms
                w.alarm_id = ($urandom_range(9, 0) == 0) ? ID_W'($urandom_range(255, 0))
                                                         : ID_W'($urandom_range(ID_COUNT - 1, 1));
                w.alarm_priority      = PRIO_W'($urandom);
                w.now_time            = ($urandom_range(15, 0) == 0) ? 32'd0 : $urandom;
                w.limit_hundredths    = VAL_W'($urandom);
                w.measured_hundredths = VAL_W'($urandom);
                w.read_index = ($urandom_range(3, 0) == 0) ? RIDX_W'($urandom_range(63, 0))
                                                           : RIDX_W'($urandom_range(LOG_DEPTH, 0));
                send_word(w, 1'b0, '0);
            end
        end

        @(negedge clk);
        req_if.valid <= 1'b0;

        // Drain outstanding responses, then let the bench idle before the final check
        drain = 0;
        while (pending_results.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d response words never arrived", pending_results.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ael_pkg.sv
rtl/core/ael_in_if.sv
rtl/core/ael_out_if.sv
rtl/core/ael_cell.sv
rtl/core/alarm_event_log_core.sv
test/alarm_event_log_core_tb.sv
